[rtl/gmd_pkg.sv]
// Package with the shared types and constants of the gzip member deframer.
package gmd_pkg;

    // Fixed header and trailer sizes of one member.
    localparam int FIXED_HDR_LEN = 10;
    localparam int TRAILER_LEN   = 8;

    // Magic bytes and the compression method byte.
    localparam logic [7:0] MAGIC_ID1  = 8'h1f;
    localparam logic [7:0] MAGIC_ID2  = 8'h8b;
    localparam logic [7:0] CM_DEFLATE = 8'h08;

    // Flag bits of the header flag byte.
    localparam logic [7:0] FL_HCRC    = 8'h02;
    localparam logic [7:0] FL_EXTRA   = 8'h04;
    localparam logic [7:0] FL_NAME    = 8'h08;
    localparam logic [7:0] FL_COMMENT = 8'h10;

    // Status codes of the summary result.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC  = 2'd1;
    localparam logic [1:0] ST_BAD_METHOD = 2'd2;
    localparam logic [1:0] ST_TRUNCATED  = 2'd3;

    // One input byte of the member.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } gmd_in_t;

    // One result: a body byte or the member summary.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        body_valid;
        logic        done_res;
        logic [1:0]  status;
        logic [31:0] trailer_crc;
        logic [31:0] trailer_size;
    } gmd_out_t;

    // Results produced by one byte, in output order.
    typedef struct packed {
        logic [1:0] count;
        gmd_out_t   first;
        gmd_out_t   second;
    } gmd_push_t;

endpackage

[rtl/gmd_parser.sv]
// Header parser, body delay line and summary builder for one byte per cycle while fire is high.
module gmd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  gmd_pkg::gmd_in_t  item,
    output gmd_pkg::gmd_push_t push
);
    import gmd_pkg::*;

    localparam logic [3:0] PH_FIXED   = 4'd0;
    localparam logic [3:0] PH_XLEN    = 4'd1;
    localparam logic [3:0] PH_XDATA   = 4'd2;
    localparam logic [3:0] PH_NAME    = 4'd3;
    localparam logic [3:0] PH_COMMENT = 4'd4;
    localparam logic [3:0] PH_HCRC    = 4'd5;
    localparam logic [3:0] PH_BODY    = 4'd6;
    localparam logic [3:0] PH_DRAIN   = 4'd7;

    localparam logic [15:0] HDR_LAST = 16'(FIXED_HDR_LEN - 1);
    localparam logic [3:0]  FULL     = 4'(TRAILER_LEN);

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] skip_reg, skip_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] xlen_reg, xlen_next;
    logic [7:0]  delay_reg [TRAILER_LEN];
    logic [7:0]  delay_next [TRAILER_LEN];
    logic [3:0]  fill_reg, fill_next;
    logic [1:0]  err_reg, err_next;
    logic        body_en;
    logic [7:0]  body_byte;
    gmd_out_t    body_res;
    gmd_out_t    sum_res;

    // Pick the first optional field at or after start that the flags enable.
    function automatic logic [3:0] enter_phase(input logic [3:0] start,
                                               input logic [7:0] flags);
        logic [3:0] ph;
        if (start <= PH_XLEN && (flags & FL_EXTRA) != 8'h00)
            ph = PH_XLEN;
        else if (start <= PH_NAME && (flags & FL_NAME) != 8'h00)
            ph = PH_NAME;
        else if (start <= PH_COMMENT && (flags & FL_COMMENT) != 8'h00)
            ph = PH_COMMENT;
        else if (start <= PH_HCRC && (flags & FL_HCRC) != 8'h00)
            ph = PH_HCRC;
        else
            ph = PH_BODY;
        return ph;
    endfunction

    // Next state of the parser for the byte in the input register.
    always_comb
    begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        flags_next = flags_reg;
        xlen_next  = xlen_reg;
        fill_next  = fill_reg;
        err_next   = err_reg;
        body_en    = 1'b0;
        body_byte  = delay_reg[0];
        for (int i = 0; i < TRAILER_LEN; i++)
        begin
            delay_next[i] = delay_reg[i];
        end

        case (phase_reg)
            PH_FIXED:
            begin
                if (skip_reg == 16'd0 && item.data_byte != MAGIC_ID1)
                begin
                    err_next   = ST_BAD_MAGIC;
                    phase_next = PH_DRAIN;
                end
                else if (skip_reg == 16'd1 && item.data_byte != MAGIC_ID2)
                begin
                    err_next   = ST_BAD_MAGIC;
                    phase_next = PH_DRAIN;
                end
                else if (skip_reg == 16'd2 && item.data_byte != CM_DEFLATE)
                begin
                    err_next   = ST_BAD_METHOD;
                    phase_next = PH_DRAIN;
                end
                else
                begin
                    if (skip_reg == 16'd3)
                        flags_next = item.data_byte;
                    if (skip_reg >= HDR_LAST)
                    begin
                        phase_next = enter_phase(PH_XLEN, flags_next);
                        skip_next  = 16'd0;
                    end
                    else
                        skip_next = skip_reg + 16'd1;
                end
            end
            PH_XLEN:
            begin
                if (skip_reg == 16'd0)
                begin
                    xlen_next = {8'h00, item.data_byte};
                    skip_next = 16'd1;
                end
                else
                begin
                    xlen_next = xlen_reg | {item.data_byte, 8'h00};
                    skip_next = 16'd0;
                    if (xlen_next == 16'd0)
                        phase_next = enter_phase(PH_NAME, flags_reg);
                    else
                        phase_next = PH_XDATA;
                end
            end
            PH_XDATA:
            begin
                skip_next = skip_reg + 16'd1;
                if (skip_next >= xlen_reg)
                begin
                    phase_next = enter_phase(PH_NAME, flags_reg);
                    skip_next  = 16'd0;
                end
            end
            PH_NAME:
            begin
                if (item.data_byte == 8'h00)
                begin
                    phase_next = enter_phase(PH_COMMENT, flags_reg);
                    skip_next  = 16'd0;
                end
            end
            PH_COMMENT:
            begin
                if (item.data_byte == 8'h00)
                begin
                    phase_next = enter_phase(PH_HCRC, flags_reg);
                    skip_next  = 16'd0;
                end
            end
            PH_HCRC:
            begin
                if (skip_reg == 16'd0)
                    skip_next = 16'd1;
                else
                begin
                    phase_next = enter_phase(PH_BODY, flags_reg);
                    skip_next  = 16'd0;
                end
            end
            PH_BODY:
            begin
                if (fill_reg >= FULL)
                begin
                    // Oldest byte leaves the delay line as a body byte.
                    body_en = 1'b1;
                    for (int i = 0; i < TRAILER_LEN - 1; i++)
                    begin
                        delay_next[i] = delay_reg[i + 1];
                    end
                    delay_next[TRAILER_LEN - 1] = item.data_byte;
                end
                else
                begin
                    delay_next[fill_reg[2:0]] = item.data_byte;
                    fill_next = fill_reg + 4'd1;
                end
            end
            default:
            begin
            end
        endcase

        // Summary on the last byte, built from the updated state.
        sum_res = '0;
        sum_res.done_res = 1'b1;
        if (err_next != ST_OK)
            sum_res.status = err_next;
        else if (phase_next != PH_BODY || fill_next < FULL)
            sum_res.status = ST_TRUNCATED;
        else
        begin
            sum_res.status       = ST_OK;
            sum_res.trailer_crc  = {delay_next[3], delay_next[2],
                                    delay_next[1], delay_next[0]};
            sum_res.trailer_size = {delay_next[7], delay_next[6],
                                    delay_next[5], delay_next[4]};
        end

        body_res = '0;
        body_res.out_byte   = body_byte;
        body_res.body_valid = 1'b1;

        // Results in output order: the body byte comes before the summary.
        push = '0;
        if (fire)
        begin
            if (body_en && item.last_byte)
            begin
                push.count  = 2'd2;
                push.first  = body_res;
                push.second = sum_res;
            end
            else if (body_en)
            begin
                push.count = 2'd1;
                push.first = body_res;
            end
            else if (item.last_byte)
            begin
                push.count = 2'd1;
                push.first = sum_res;
            end
        end
    end

    // Parser state; the last byte returns everything to the reset state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIXED;
            skip_reg  <= 16'd0;
            flags_reg <= 8'h00;
            xlen_reg  <= 16'd0;
            fill_reg  <= 4'd0;
            err_reg   <= ST_OK;
            for (int i = 0; i < TRAILER_LEN; i++)
            begin
                delay_reg[i] <= 8'h00;
            end
        end
        else if (fire)
        begin
            if (item.last_byte)
            begin
                phase_reg <= PH_FIXED;
                skip_reg  <= 16'd0;
                flags_reg <= 8'h00;
                xlen_reg  <= 16'd0;
                fill_reg  <= 4'd0;
                err_reg   <= ST_OK;
                for (int i = 0; i < TRAILER_LEN; i++)
                begin
                    delay_reg[i] <= 8'h00;
                end
            end
            else
            begin
                phase_reg <= phase_next;
                skip_reg  <= skip_next;
                flags_reg <= flags_next;
                xlen_reg  <= xlen_next;
                fill_reg  <= fill_next;
                err_reg   <= err_next;
                for (int i = 0; i < TRAILER_LEN; i++)
                begin
                    delay_reg[i] <= delay_next[i];
                end
            end
        end
    end

endmodule

[rtl/gmd_result_fifo.sv]
// Four-entry result queue that takes up to two results and gives one per cycle while res_stall is low.
module gmd_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  gmd_pkg::gmd_push_t push,
    output logic               has_room,
    output logic               res_valid,
    input  logic               res_stall,
    output gmd_pkg::gmd_out_t  res_item
);
    import gmd_pkg::*;

    localparam int DEPTH = 4;

    gmd_out_t   mem_reg [DEPTH];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    // Room for two pushes is judged from the registered count alone.
    assign has_room  = (count_reg <= 3'd2);
    assign res_valid = (count_reg != 3'd0);
    assign res_item  = mem_reg[rd_reg];
    assign pop       = res_valid && !res_stall;

    // Pointer and count update.
    always_comb
    begin
        wr_next    = wr_reg + 2'(push.count);
        rd_next    = pop ? rd_reg + 2'd1 : rd_reg;
        count_next = count_reg + 3'(push.count) - 3'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 2'd0;
            rd_reg    <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Result storage; entries need no reset.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_reg + 2'd1] <= push.second;
    end

endmodule

[rtl/gzip_member_deframer.sv]
// Top level of the gzip member deframer: input register, parser and result queue.
//
//  channel | direction | handshake              | payload
//  byte    | in        | byte_valid / byte_stall | gmd_in_t  (data_byte, last_byte)
//  res     | out       | res_valid / res_stall   | gmd_out_t (body byte or summary)
//
// One byte per cycle is taken in steady flow. A byte is parsed in the cycle
// in which it leaves the input register, and its results are written into
// the result queue at the end of that cycle. The last byte can give two
// results; the four-entry queue absorbs the extra one and drains one result
// per cycle while res_stall is low. Reset returns the parser to the start of
// a member and empties the queue. A stall on the result side backs up into
// byte_stall once the queue lacks room for two results.
module gzip_member_deframer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  gmd_pkg::gmd_in_t  byte_item,
    output logic              res_valid,
    input  logic              res_stall,
    output gmd_pkg::gmd_out_t res_item
);
    import gmd_pkg::*;

    logic      in_valid_reg;
    gmd_in_t   in_item_reg;
    logic      has_room;
    logic      fire;
    logic      accept;
    gmd_push_t push;

    // The registered byte is parsed when the queue can take two results.
    assign fire       = in_valid_reg && has_room;
    assign byte_stall = in_valid_reg && !has_room;
    assign accept     = byte_valid && !byte_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= byte_item;
    end

    gmd_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .push  (push)
    );

    gmd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .has_room  (has_room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

[rtl/gmd_checker.sv]
// Port-level checker for the gzip member deframer and its bind.
module gmd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              byte_valid,
    input logic              byte_stall,
    input gmd_pkg::gmd_in_t  byte_item,
    input logic              res_valid,
    input logic              res_stall,
    input gmd_pkg::gmd_out_t res_item
);
    import gmd_pkg::*;

    // A stalled result stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result valid dropped under stall");

    // A stalled result keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_item))
        else $error("result payload changed under stall");

    // A result is either a body byte or a summary, never both.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.body_valid != res_item.done_res))
        else $error("result kind is not exactly one of body or summary");

    // Trailer words are zero unless the summary reports success.
    a_trailer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !(res_item.done_res && res_item.status == ST_OK)
        |-> (res_item.trailer_crc == 32'd0 && res_item.trailer_size == 32'd0))
        else $error("trailer words set outside a good summary");

    // A last byte taken while no result is offered, with byte_stall low after it, shows a result.
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall && byte_item.last_byte && !res_valid
        && !byte_stall ##1 !byte_stall |=> res_valid)
        else $error("last byte gave no summary");

endmodule

bind gzip_member_deframer gmd_checker u_gmd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
);

[bench/gzip_member_deframer_tb.sv]
// Self-checking testbench for the gzip member deframer with a built-in framing predictor.
module gzip_member_deframer_tb;

    import gmd_pkg::*;

    localparam int ITEMS_PER_PHASE = 330;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 16;

    // Parser phases of the predictor, in header order.
    typedef enum logic [2:0] {
        P_FIXED,
        P_XLEN,
        P_XDATA,
        P_NAME,
        P_COMMENT,
        P_HCRC,
        P_BODY,
        P_DRAIN
    } parse_phase_e;

    logic     clk;
    logic     rst_n;
    logic     byte_valid = 1'b0;
    logic     byte_stall;
    gmd_in_t  byte_item  = '0;
    logic     res_valid;
    logic     res_stall  = 1'b0;
    gmd_out_t res_item;

    // Byte transactions waiting to be sent and results waiting to arrive.
    gmd_in_t  member_bytes[$];
    gmd_out_t predicted_results[$];
    logic [7:0] member_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors        = 0;
    int cycles        = 0;
    int members_sent  = 0;
    int bytes_sent    = 0;
    int body_seen     = 0;
    int status_seen[4];

    // Predictor state for the member being parsed.
    parse_phase_e phase;
    logic [15:0]  skip_cnt;
    logic [7:0]   hdr_flags;
    logic [15:0]  xlen;
    logic [7:0]   dly[8];
    logic [3:0]   fill;
    logic [1:0]   err_code;

    gzip_member_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_item (byte_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    // Free-running clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Return the predictor to the start of a member.
    task automatic clear_parser();
        phase     = P_FIXED;
        skip_cnt  = '0;
        hdr_flags = '0;
        xlen      = '0;
        for (int i = 0; i < 8; i++)
            dly[i] = '0;
        fill      = '0;
        err_code  = '0;
    endtask

    // Move to the first optional field at or after start that the flags enable.
    task automatic next_field(input parse_phase_e start);
        skip_cnt = '0;
        if (start <= P_XLEN && (hdr_flags & FL_EXTRA) != 0)
            phase = P_XLEN;
        else if (start <= P_NAME && (hdr_flags & FL_NAME) != 0)
            phase = P_NAME;
        else if (start <= P_COMMENT && (hdr_flags & FL_COMMENT) != 0)
            phase = P_COMMENT;
        else if (start <= P_HCRC && (hdr_flags & FL_HCRC) != 0)
            phase = P_HCRC;
        else
            phase = P_BODY;
    endtask

    task automatic flag_error(input logic [1:0] code);
        err_code = code;
        phase    = P_DRAIN;
    endtask

    task automatic push_result(input logic [7:0] ob, input logic bv, input logic dn,
                               input logic [1:0] st, input logic [31:0] crc,
                               input logic [31:0] sz);
        gmd_out_t r;
        r.out_byte     = ob;
        r.body_valid   = bv;
        r.done_res     = dn;
        r.status       = st;
        r.trailer_crc  = crc;
        r.trailer_size = sz;
        predicted_results.push_back(r);
    endtask

    // Work out the results that one accepted byte causes.
    task automatic deframe_byte(input logic [7:0] b, input logic lst);
        case (phase)
            P_FIXED:
            begin
                if (skip_cnt == 0 && b != MAGIC_ID1)
                    flag_error(ST_BAD_MAGIC);
                else if (skip_cnt == 1 && b != MAGIC_ID2)
                    flag_error(ST_BAD_MAGIC);
                else if (skip_cnt == 2 && b != CM_DEFLATE)
                    flag_error(ST_BAD_METHOD);
                else
                begin
                    if (skip_cnt == 3)
                        hdr_flags = b;
                    if (skip_cnt >= FIXED_HDR_LEN - 1)
                        next_field(P_XLEN);
                    else
                        skip_cnt = skip_cnt + 16'd1;
                end
            end
            P_XLEN:
            begin
                if (skip_cnt == 0)
                begin
                    xlen     = {8'h00, b};
                    skip_cnt = 16'd1;
                end
                else
                begin
                    xlen = xlen | {b, 8'h00};
                    if (xlen == 0)
                        next_field(P_NAME);
                    else
                    begin
                        phase    = P_XDATA;
                        skip_cnt = '0;
                    end
                end
            end
            P_XDATA:
            begin
                skip_cnt = skip_cnt + 16'd1;
                if (skip_cnt >= xlen)
                    next_field(P_NAME);
            end
            P_NAME:
            begin
                if (b == 0)
                    next_field(P_COMMENT);
            end
            P_COMMENT:
            begin
                if (b == 0)
                    next_field(P_HCRC);
            end
            P_HCRC:
            begin
                if (skip_cnt == 0)
                    skip_cnt = 16'd1;
                else
                    next_field(P_BODY);
            end
            P_BODY:
            begin
                // The delay line holds back the final eight bytes as the trailer.
                if (fill >= TRAILER_LEN)
                begin
                    push_result(dly[0], 1'b1, 1'b0, ST_OK, '0, '0);
                    for (int i = 0; i < 7; i++)
                        dly[i] = dly[i + 1];
                    dly[7] = b;
                end
                else
                begin
                    dly[fill[2:0]] = b;
                    fill = fill + 4'd1;
                end
            end
            default:
            begin
            end
        endcase

        // The last byte closes the member with a summary.
        if (lst)
        begin
            if (err_code != ST_OK)
                push_result('0, 1'b0, 1'b1, err_code, '0, '0);
            else if (phase != P_BODY || fill < TRAILER_LEN)
                push_result('0, 1'b0, 1'b1, ST_TRUNCATED, '0, '0);
            else
                push_result('0, 1'b0, 1'b1, ST_OK, {dly[3], dly[2], dly[1], dly[0]},
                            {dly[7], dly[6], dly[5], dly[4]});
            clear_parser();
        end
    endtask

    // Hand the built member over to the driver, marking its final byte.
    function automatic int commit_member();
        gmd_in_t it;
        int n;
        n = member_q.size();
        for (int i = 0; i < n; i++)
        begin
            it.data_byte = member_q[i];
            it.last_byte = (i == n - 1);
            member_bytes.push_back(it);
        end
        members_sent++;
        bytes_sent += n;
        return n;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Zero-terminated string with up to five nonzero characters.
    task automatic add_zstring();
        int n;
        n = $urandom_range(0, 5);
        repeat (n)
            member_q.push_back(8'($urandom_range(1, 255)));
        member_q.push_back(8'h00);
    endtask

    // Build a well-formed member with random flags, fields and body.
    task automatic build_good();
        logic [7:0]  flags;
        logic [15:0] xl;
        int          body_len;
        member_q.delete();
        flags = rand_byte();
        member_q.push_back(MAGIC_ID1);
        member_q.push_back(MAGIC_ID2);
        member_q.push_back(CM_DEFLATE);
        member_q.push_back(flags);
        repeat (FIXED_HDR_LEN - 4)
            member_q.push_back(rand_byte());
        if ((flags & FL_EXTRA) != 0)
        begin
            xl = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(256, 320))
                                              : 16'($urandom_range(0, 6));
            member_q.push_back(xl[7:0]);
            member_q.push_back(xl[15:8]);
            repeat (xl)
                member_q.push_back(rand_byte());
        end
        if ((flags & FL_NAME) != 0)
            add_zstring();
        if ((flags & FL_COMMENT) != 0)
            add_zstring();
        if ((flags & FL_HCRC) != 0)
            repeat (2)
                member_q.push_back(rand_byte());
        body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                               : $urandom_range(0, 12);
        repeat (body_len + TRAILER_LEN)
            member_q.push_back(rand_byte());
    endtask

    // Pick one random member: mostly well-formed, some cut short, corrupted or noise.
    task automatic build_random();
        int pick;
        int cut;
        int pos;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            build_good();
        else if (pick < 80)
        begin
            build_good();
            cut = $urandom_range(1, member_q.size() - 1);
            while (member_q.size() > cut)
                member_q.delete(member_q.size() - 1);
        end
        else if (pick < 90)
        begin
            build_good();
            pos = $urandom_range(0, 2);
            member_q[pos] = member_q[pos] ^ 8'($urandom_range(1, 255));
            // Sometimes the bad byte is the final one.
            if ($urandom_range(0, 3) == 0)
                while (member_q.size() > pos + 1)
                    member_q.delete(member_q.size() - 1);
        end
        else
        begin
            member_q.delete();
            repeat ($urandom_range(1, 20))
                member_q.push_back(rand_byte());
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        int added;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        added = 0;
        while (added < ITEMS_PER_PHASE)
        begin
            build_random();
            added += commit_member();
        end
        while (member_bytes.size() != 0 || byte_valid)
            @(posedge clk);
    endtask

    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            errors++;
        end
    endfunction

    // Driver: present the next byte transaction once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        logic took;
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_item  <= '0;
        end
        else
        begin
            took = byte_valid && !byte_stall;
            if (took)
                deframe_byte(byte_item.data_byte, byte_item.last_byte);
            if (!byte_valid || took)
            begin
                if (member_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    byte_valid <= 1'b1;
                    byte_item  <= member_bytes.pop_front();
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
            res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Monitor: compare every accepted result transaction with the oldest prediction.
    always @(posedge clk)
    begin : result_monitor
        gmd_out_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (predicted_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, res_item);
                errors++;
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("out_byte", 32'(want.out_byte), 32'(res_item.out_byte));
                check_field("body_valid", 32'(want.body_valid), 32'(res_item.body_valid));
                check_field("done_res", 32'(want.done_res), 32'(res_item.done_res));
                check_field("status", 32'(want.status), 32'(res_item.status));
                check_field("trailer_crc", want.trailer_crc, res_item.trailer_crc);
                check_field("trailer_size", want.trailer_size, res_item.trailer_size);
            end
            if (res_item.body_valid)
                body_seen++;
            if (res_item.done_res)
                status_seen[res_item.status]++;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus sequence and end of run.
    initial
    begin
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;
        clear_parser();
        rst_n = 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 69;

        // Directed members: shortest valid member with zero extra length and
        // unused flag bits set, then bad magic, bad method and truncation on
        // the last byte.
        member_q = '{8'h1f, 8'h8b, 8'h08, 8'he5, 8'hff, 8'h00, 8'hff, 8'h00,
                     8'h00, 8'hff, 8'h00, 8'h00, 8'h01, 8'h23, 8'h45, 8'h67,
                     8'hff, 8'hff, 8'hff, 8'hff};
        void'(commit_member());
        member_q = '{8'hff};
        void'(commit_member());
        member_q = '{8'h1f, 8'h8b, 8'h09};
        void'(commit_member());
        member_q = '{8'h1f};
        void'(commit_member());

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        run_phase(26, 69);
        run_phase(69, 26);
        run_phase(0, 0);

        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Sent %0d members in %0d bytes; received %0d body bytes.",
                 members_sent, bytes_sent, body_seen);
        $display("Summaries: %0d ok, %0d bad magic, %0d bad method, %0d truncated.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
